### design/lpc_pkg.sv
// shared types and constants of the lfsr pc accumulator cpu
package lpc_pkg;

  localparam int WORD_W   = 16;
  localparam int IMM_W    = 12;
  localparam int ADDR_IN_W = 13;
  localparam int TAPS_W   = 8;

  // bit 15 marks an indirect operand in an instruction and the i/o space in an address
  localparam int IND_BIT  = 15;
  localparam int PORT_BIT = 15;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 8'hB8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [2:0] {
    OP_AND   = 3'd0,
    OP_XOR   = 3'd1,
    OP_SHL   = 3'd2,
    OP_SHR   = 3'd3,
    OP_LOAD  = 3'd4,
    OP_STORE = 3'd5,
    OP_JMP   = 3'd6,
    OP_JZ    = 3'd7
  } op_t;

endpackage

### design/lfsr_pc_accumulator_cpu.sv
// top level of the lfsr pc accumulator cpu: sequencer, registers and handshakes
//
// A 16-bit accumulator machine whose program counter steps by an 8-bit Galois
// LFSR (feedback mask in cfg_data, 0xB8 after reset). A write word (cmd 0) stores
// one memory word; a step word (cmd 1) executes one instruction: the fetch, an
// operand read with an indirect operand, and a data read for a load from memory.
// The order is set by the one read port of the main memory: fetch, operand
// and load data come one after another, each in the cycle after its address. After
// reset a clearing pass zeroes every memory word, and no input word is accepted
// meanwhile; the tap register can be written at any time. One input word is
// buffered while another executes; a finished result waits in the output register,
// and the buffered word starts only in a cycle where that register is empty or
// its result word is being taken.
module lfsr_pc_accumulator_cpu #(
  parameter int MEM_WORDS = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [lpc_pkg::ADDR_IN_W-1:0] in_mem_addr,
  input  logic [lpc_pkg::WORD_W-1:0]    in_mem_data,
  input  logic [lpc_pkg::WORD_W-1:0]    in_in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpc_pkg::WORD_W-1:0]    out_pc_now,
  output logic [lpc_pkg::WORD_W-1:0]    out_acc_now,
  output logic                          out_out_valid,
  output logic [lpc_pkg::WORD_W-1:0]    out_out_data,
  output logic                          out_in_taken,
  output logic                          out_halted,
  // configuration
  input  logic                          cfg_we,
  input  logic [lpc_pkg::TAPS_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int WW = lpc_pkg::WORD_W;
  localparam logic [19:0] MW = 20'(MEM_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_ARG,
    S_LD
  } state_t;

  // address modulo the memory depth, by conditional subtraction of depth multiples
  function automatic logic [AW-1:0] mem_index(input logic [WW-1:0] a);
    logic [19:0] r;
    r = {4'b0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (MW << k)) begin
        r = r - (MW << k);
      end
    end
    return r[AW-1:0];
  endfunction

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_idx_r, clr_idx_nxt;
  logic [WW-1:0]               pc_r, pc_nxt;
  logic [WW-1:0]               acc_r, acc_nxt;
  logic [WW-1:0]               ins_r, ins_nxt;
  logic [lpc_pkg::TAPS_W-1:0]  taps_r;

  // input buffer
  logic                          ib_vld_r;
  logic                          ib_cmd_r;
  logic [lpc_pkg::ADDR_IN_W-1:0] ib_addr_r;
  logic [WW-1:0]                 ib_data_r;
  logic [WW-1:0]                 ib_in_r;
  logic [WW-1:0]                 cur_in_r;

  // output register
  logic          out_vld_r;
  logic [WW-1:0] o_pc_r, o_acc_r, o_data_r;
  logic          o_port_r, o_taken_r, o_halt_r;

  // memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic          ib_pop, fin, exec, out_free;
  logic          res_port, res_taken, res_halt;
  logic [WW-1:0] res_data;
  logic [WW-1:0] ins_cur, arg;
  logic [WW-1:0] lfsr_nxt;
  logic [lpc_pkg::TAPS_W-1:0] lfsr_s;
  lpc_pkg::op_t  op;

  lpc_ram #(
    .DEPTH (MEM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_vld_r || out_ready;
  assign in_ready = (state_r != S_CLEAR) && (!ib_vld_r || ib_pop);

  // lfsr successor of the low byte of pc
  assign lfsr_s   = pc_r[7:0];
  assign lfsr_nxt = {8'b0, ({1'b0, lfsr_s[7:1]} ^ (lfsr_s[0] ? taps_r : 8'h00))};

  // instruction and operand as they are available in the current state
  assign ins_cur = (state_r == S_INS) ? ram_rdata : ins_r;
  assign arg     = (state_r == S_ARG) ? ram_rdata
                                      : {{(WW-lpc_pkg::IMM_W){1'b0}},
                                         ins_cur[lpc_pkg::IMM_W-1:0]};
  assign op      = lpc_pkg::op_t'(ins_cur[14:12]);

  // sequencer: fetch, operand, load and write-back
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    pc_nxt      = pc_r;
    acc_nxt     = acc_r;
    ins_nxt     = ins_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    ib_pop      = 1'b0;
    fin         = 1'b0;
    exec        = 1'b0;
    res_port    = 1'b0;
    res_data    = '0;
    res_taken   = 1'b0;
    res_halt    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        if (clr_idx_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (ib_vld_r && out_free) begin
          ib_pop = 1'b1;
          if (ib_cmd_r == lpc_pkg::CMD_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = mem_index({{(WW-lpc_pkg::ADDR_IN_W){1'b0}}, ib_addr_r});
            ram_wdata = ib_data_r;
            fin       = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = mem_index(pc_r);
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        ins_nxt = ram_rdata;
        if (ram_rdata[lpc_pkg::IND_BIT]) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ram_rdata[lpc_pkg::IMM_W-1:0]);
          state_nxt = S_ARG;
        end else begin
          exec = 1'b1;
        end
      end
      S_ARG: begin
        exec = 1'b1;
      end
      S_LD: begin
        acc_nxt   = ram_rdata;
        pc_nxt    = lfsr_nxt;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // execute with the operand in hand
    if (exec) begin
      fin       = 1'b1;
      state_nxt = S_IDLE;
      case (op)
        lpc_pkg::OP_AND: begin
          acc_nxt = acc_r & arg;
          pc_nxt  = lfsr_nxt;
        end
        lpc_pkg::OP_XOR: begin
          acc_nxt = acc_r ^ arg;
          pc_nxt  = lfsr_nxt;
        end
        lpc_pkg::OP_SHL: begin
          acc_nxt = {acc_r[WW-2:0], 1'b0};
          pc_nxt  = lfsr_nxt;
        end
        lpc_pkg::OP_SHR: begin
          acc_nxt = {1'b0, acc_r[WW-1:1]};
          pc_nxt  = lfsr_nxt;
        end
        lpc_pkg::OP_LOAD: begin
          if (arg[lpc_pkg::PORT_BIT]) begin
            acc_nxt   = cur_in_r;
            res_taken = 1'b1;
            pc_nxt    = lfsr_nxt;
          end else begin
            fin       = 1'b0;
            ram_re    = 1'b1;
            ram_raddr = mem_index(arg);
            state_nxt = S_LD;
          end
        end
        lpc_pkg::OP_STORE: begin
          if (arg[lpc_pkg::PORT_BIT]) begin
            res_port = 1'b1;
            res_data = acc_r;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = mem_index(arg);
            ram_wdata = acc_r;
          end
          pc_nxt = lfsr_nxt;
        end
        lpc_pkg::OP_JMP: begin
          if (pc_r == arg) begin
            res_halt = 1'b1;
          end else begin
            pc_nxt = arg;
          end
        end
        lpc_pkg::OP_JZ: begin
          pc_nxt = (acc_r != '0) ? lfsr_nxt : arg;
        end
        default: begin
          pc_nxt = lfsr_nxt;
        end
      endcase
    end
  end

  // state, buffers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      pc_r      <= '0;
      acc_r     <= '0;
      taps_r    <= lpc_pkg::TAPS_RESET;
      ib_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      pc_r      <= pc_nxt;
      acc_r     <= acc_nxt;
      ins_r     <= ins_nxt;

      // tap register write
      if (cfg_we) begin
        taps_r <= cfg_data;
      end

      // input buffer fill and drain
      if (in_valid && in_ready) begin
        ib_vld_r  <= 1'b1;
        ib_cmd_r  <= in_cmd;
        ib_addr_r <= in_mem_addr;
        ib_data_r <= in_mem_data;
        ib_in_r   <= in_in_data;
      end else if (ib_pop) begin
        ib_vld_r <= 1'b0;
      end

      // port value of the word in execution
      if (ib_pop) begin
        cur_in_r <= ib_in_r;
      end

      // result word
      if (fin) begin
        out_vld_r <= 1'b1;
        o_pc_r    <= pc_nxt;
        o_acc_r   <= acc_nxt;
        o_port_r  <= res_port;
        o_data_r  <= res_data;
        o_taken_r <= res_taken;
        o_halt_r  <= res_halt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pc_now    = o_pc_r;
  assign out_acc_now   = o_acc_r;
  assign out_out_valid = o_port_r;
  assign out_out_data  = o_data_r;
  assign out_in_taken  = o_taken_r;
  assign out_halted    = o_halt_r;

endmodule

### design/lpc_ram.sv
// single write port, single read port memory with registered read data
module lpc_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lpc_pkg::WORD_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [lpc_pkg::WORD_W-1:0]  rdata
);

  logic [lpc_pkg::WORD_W-1:0] mem [DEPTH];
  logic [lpc_pkg::WORD_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### test/testbench.sv
// self-checking testbench of the lfsr pc accumulator cpu with a scoreboard class
module testbench;

  localparam int MEM_WORDS   = 8192;
  localparam int WORD_GOAL   = 1850;
  localparam int PHASES      = 6;
  // the clearing pass after reset alone has no handshake on either channel
  localparam int STALL_LIMIT = 4 * MEM_WORDS;
  localparam int MAX_REPORTS = 10;

  // what one result word carries
  typedef struct packed {
    logic [lpc_pkg::WORD_W-1:0] pc_now;
    logic [lpc_pkg::WORD_W-1:0] acc_now;
    logic                       port_wr;
    logic [lpc_pkg::WORD_W-1:0] port_data;
    logic                       port_rd;
    logic                       halted;
  } cpu_view_t;

  // cpu shadow plus the queue of result words still owed by the block
  class cpu_scoreboard;
    bit [lpc_pkg::WORD_W-1:0] memory [MEM_WORDS];
    bit [lpc_pkg::WORD_W-1:0] pc;
    bit [lpc_pkg::WORD_W-1:0] acc;
    bit [lpc_pkg::TAPS_W-1:0] taps;
    cpu_view_t                awaited [$];
    int                       mismatches;

    function new();
      pc         = '0;
      acc        = '0;
      taps       = lpc_pkg::TAPS_RESET;
      mismatches = 0;
    endfunction

    // galois step on the low byte of the program counter
    function bit [lpc_pkg::WORD_W-1:0] pc_successor();
      bit [lpc_pkg::TAPS_W-1:0] s;
      s = pc[lpc_pkg::TAPS_W-1:0] >> 1;
      if (pc[0]) begin
        s = s ^ taps;
      end
      return {{(lpc_pkg::WORD_W-lpc_pkg::TAPS_W){1'b0}}, s};
    endfunction

    // apply one accepted input word and queue the result it must produce
    function void note_word(logic cmd, logic [lpc_pkg::ADDR_IN_W-1:0] addr,
                            logic [lpc_pkg::WORD_W-1:0] data,
                            logic [lpc_pkg::WORD_W-1:0] port_in);
      cpu_view_t                r;
      bit [lpc_pkg::WORD_W-1:0] ins;
      bit [lpc_pkg::WORD_W-1:0] arg;
      bit [lpc_pkg::WORD_W-1:0] nxt;
      lpc_pkg::op_t             op;
      r = '0;
      if (cmd == lpc_pkg::CMD_WRITE) begin
        memory[addr % MEM_WORDS] = data;
      end else begin
        ins = memory[pc % MEM_WORDS];
        op  = lpc_pkg::op_t'(ins[lpc_pkg::IND_BIT-1:lpc_pkg::IMM_W]);
        nxt = pc_successor();
        arg = {{(lpc_pkg::WORD_W-lpc_pkg::IMM_W){1'b0}}, ins[lpc_pkg::IMM_W-1:0]};
        if (ins[lpc_pkg::IND_BIT]) begin
          arg = memory[arg % MEM_WORDS];
        end
        case (op)
          lpc_pkg::OP_AND: begin
            acc = acc & arg;
            pc  = nxt;
          end
          lpc_pkg::OP_XOR: begin
            acc = acc ^ arg;
            pc  = nxt;
          end
          lpc_pkg::OP_SHL: begin
            acc = acc << 1;
            pc  = nxt;
          end
          lpc_pkg::OP_SHR: begin
            acc = acc >> 1;
            pc  = nxt;
          end
          lpc_pkg::OP_LOAD: begin
            if (arg[lpc_pkg::PORT_BIT]) begin
              acc       = port_in;
              r.port_rd = 1'b1;
            end else begin
              acc = memory[arg % MEM_WORDS];
            end
            pc = nxt;
          end
          lpc_pkg::OP_STORE: begin
            if (arg[lpc_pkg::PORT_BIT]) begin
              r.port_wr   = 1'b1;
              r.port_data = acc;
            end else begin
              memory[arg % MEM_WORDS] = acc;
            end
            pc = nxt;
          end
          lpc_pkg::OP_JMP: begin
            if (pc == arg) begin
              r.halted = 1'b1;
            end else begin
              pc = arg;
            end
          end
          default: begin
            pc = (acc != 0) ? nxt : arg;
          end
        endcase
      end
      r.pc_now  = pc;
      r.acc_now = acc;
      awaited.push_back(r);
    endfunction

    function void report(string what, cpu_view_t want, cpu_view_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s: expected pc=%h acc=%h out=%b/%h in=%b halt=%b",
                 what, want.pc_now, want.acc_now, want.port_wr, want.port_data,
                 want.port_rd, want.halted);
        $display("    actual   pc=%h acc=%h out=%b/%h in=%b halt=%b",
                 got.pc_now, got.acc_now, got.port_wr, got.port_data,
                 got.port_rd, got.halted);
      end
    endfunction

    // compare an accepted result word with the oldest one owed
    function void check_result(cpu_view_t got);
      cpu_view_t want;
      if (awaited.size() == 0) begin
        report("unexpected result word", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.pc_now !== want.pc_now || got.acc_now !== want.acc_now ||
          got.port_wr !== want.port_wr || got.port_data !== want.port_data ||
          got.port_rd !== want.port_rd || got.halted !== want.halted) begin
        report("result word mismatch", want, got);
      end
    endfunction
  endclass

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic                          in_cmd      = lpc_pkg::CMD_WRITE;
  logic [lpc_pkg::ADDR_IN_W-1:0] in_mem_addr = '0;
  logic [lpc_pkg::WORD_W-1:0]    in_mem_data = '0;
  logic [lpc_pkg::WORD_W-1:0]    in_in_data  = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [lpc_pkg::WORD_W-1:0]    out_pc_now;
  logic [lpc_pkg::WORD_W-1:0]    out_acc_now;
  logic                          out_out_valid;
  logic [lpc_pkg::WORD_W-1:0]    out_out_data;
  logic                          out_in_taken;
  logic                          out_halted;
  logic                          cfg_we      = 1'b0;
  logic [lpc_pkg::TAPS_W-1:0]    cfg_data    = lpc_pkg::TAPS_RESET;

  cpu_scoreboard board;
  bit            calm         = 1'b0;
  int            words_sent   = 0;
  int            stall_left   = 0;
  int            quiet_cycles = 0;

  lfsr_pc_accumulator_cpu #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_mem_addr  (in_mem_addr),
    .in_mem_data  (in_mem_data),
    .in_in_data   (in_in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pc_now   (out_pc_now),
    .out_acc_now  (out_acc_now),
    .out_out_valid(out_out_valid),
    .out_out_data (out_out_data),
    .out_in_taken (out_in_taken),
    .out_halted   (out_halted),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // result side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result({out_pc_now, out_acc_now, out_out_valid, out_out_data,
                          out_in_taken, out_halted});
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("lfsr_pc_accumulator_cpu test failed");
      $finish;
    end
  end

  // present one input word and hold it until accepted; valid stays high afterwards
  task automatic send_word(logic cmd, logic [lpc_pkg::ADDR_IN_W-1:0] addr,
                           logic [lpc_pkg::WORD_W-1:0] data,
                           logic [lpc_pkg::WORD_W-1:0] port_in);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_mem_addr <= addr;
    in_mem_data <= data;
    in_in_data  <= port_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(cmd, addr, data, port_in);
    words_sent++;
  endtask

  // place an instruction where the program counter points, then execute it
  task automatic run_instr(logic [lpc_pkg::WORD_W-1:0] ins,
                           logic [lpc_pkg::WORD_W-1:0] port_in);
    send_word(lpc_pkg::CMD_WRITE, lpc_pkg::ADDR_IN_W'(board.pc % MEM_WORDS), ins,
              lpc_pkg::WORD_W'($urandom));
    send_word(lpc_pkg::CMD_STEP, lpc_pkg::ADDR_IN_W'($urandom),
              lpc_pkg::WORD_W'($urandom), port_in);
  endtask

  // hold the sender until every owed result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_taps(logic [lpc_pkg::TAPS_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    board.taps = value;
    @(posedge clk);
  endtask

  function automatic logic [lpc_pkg::WORD_W-1:0] instr(logic ind, lpc_pkg::op_t op,
                                                       logic [lpc_pkg::IMM_W-1:0] imm);
    return {ind, op, imm};
  endfunction

  // operands lean on a small data window, the current pc and the full range
  function automatic logic [lpc_pkg::WORD_W-1:0] random_instr();
    lpc_pkg::op_t              op;
    logic [lpc_pkg::IMM_W-1:0] imm;
    op = lpc_pkg::op_t'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: imm = lpc_pkg::IMM_W'($urandom_range(0, 15));
      1: imm = lpc_pkg::IMM_W'($urandom_range(0, 255));
      2: imm = board.pc[lpc_pkg::IMM_W-1:0];
      default: imm = lpc_pkg::IMM_W'($urandom);
    endcase
    return instr(1'($urandom), op, imm);
  endfunction

  // mostly short programs built at the pc, with stray writes and bare steps
  task automatic random_phase(int words);
    int stop;
    stop = words_sent + words;
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_instr(random_instr(), lpc_pkg::WORD_W'($urandom));
        5, 6: send_word(lpc_pkg::CMD_STEP, lpc_pkg::ADDR_IN_W'($urandom),
                        lpc_pkg::WORD_W'($urandom), lpc_pkg::WORD_W'($urandom));
        7: send_word(lpc_pkg::CMD_WRITE, lpc_pkg::ADDR_IN_W'($urandom_range(0, 15)),
                     $urandom_range(0, 1) ? (16'h8000 | lpc_pkg::WORD_W'($urandom))
                                          : lpc_pkg::WORD_W'($urandom),
                     lpc_pkg::WORD_W'($urandom));
        default: send_word(lpc_pkg::CMD_WRITE, lpc_pkg::ADDR_IN_W'($urandom),
                           lpc_pkg::WORD_W'($urandom), lpc_pkg::WORD_W'($urandom));
      endcase
    end
  endtask

  // stimulus sequence
  initial begin
    logic [lpc_pkg::TAPS_W-1:0] taps_plan [PHASES];
    int                         words;
    board = new();
    taps_plan[0] = lpc_pkg::TAPS_RESET;
    taps_plan[1] = 8'h00;
    taps_plan[2] = 8'hFF;
    taps_plan[3] = lpc_pkg::TAPS_W'($urandom);
    taps_plan[4] = lpc_pkg::TAPS_W'($urandom);
    taps_plan[5] = 8'h01;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // step on cleared memory, then extreme words and operand pointers
    send_word(lpc_pkg::CMD_STEP, '1, '1, '0);
    send_word(lpc_pkg::CMD_WRITE, '1, '1, '0);
    send_word(lpc_pkg::CMD_WRITE, 13'h0FFF, 16'h8000, '1);
    send_word(lpc_pkg::CMD_WRITE, 13'h0010, 16'h7FFF, '0);
    // jump if zero taken with a cleared accumulator
    run_instr(instr(1'b0, lpc_pkg::OP_JZ, 12'h0FF), '0);
    run_instr(instr(1'b0, lpc_pkg::OP_XOR, 12'hFFF), '0);
    run_instr(instr(1'b0, lpc_pkg::OP_SHL, 12'h000), '0);
    // indirect pointer into the i/o space: port read and port write
    run_instr(instr(1'b1, lpc_pkg::OP_LOAD, 12'hFFF), 16'hFFFF);
    run_instr(instr(1'b1, lpc_pkg::OP_STORE, 12'hFFF), '0);
    run_instr(instr(1'b0, lpc_pkg::OP_SHR, 12'h000), '0);
    // pointer beyond the memory size wraps to the top word
    run_instr(instr(1'b1, lpc_pkg::OP_LOAD, 12'h010), '0);
    run_instr(instr(1'b0, lpc_pkg::OP_JZ, 12'h020), '0);
    // jump to its own address halts, and halts again on the next step
    run_instr(instr(1'b0, lpc_pkg::OP_JMP, board.pc[lpc_pkg::IMM_W-1:0]), '0);
    send_word(lpc_pkg::CMD_STEP, '0, '0, '1);
    // indirect jump to a pc above the memory size
    run_instr(instr(1'b1, lpc_pkg::OP_JMP, 12'hFFF), '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_taps(taps_plan[ph]);
      if (ph == PHASES - 1) begin
        calm = 1'b1;
      end
      words = (WORD_GOAL - words_sent) / (PHASES - ph);
      random_phase(words);
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("lfsr_pc_accumulator_cpu test passed");
    end else begin
      $display("lfsr_pc_accumulator_cpu test failed");
    end
    $finish;
  end

endmodule

### sim.f
design/lpc_pkg.sv
design/lpc_ram.sv
design/lfsr_pc_accumulator_cpu.sv
test/testbench.sv
